FILE: rtl/sic_pkg.sv
// shared types and constants for the segment intersection classifier
package sic_pkg;

  localparam int FIELD_W = 16;
  localparam int OUT_W   = 24;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

  typedef enum logic [1:0] {
    REL_NONE     = 2'd0,
    REL_HIT      = 2'd1,
    REL_PARALLEL = 2'd2,
    REL_OVERLAP  = 2'd3
  } rel_e;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a_start_x;
    logic signed [FIELD_W-1:0] a_start_y;
    logic signed [FIELD_W-1:0] a_end_x;
    logic signed [FIELD_W-1:0] a_end_y;
    logic signed [FIELD_W-1:0] b_start_x;
    logic signed [FIELD_W-1:0] b_start_y;
    logic signed [FIELD_W-1:0] b_end_x;
    logic signed [FIELD_W-1:0] b_end_y;
  } sic_in_t;

  typedef struct packed {
    rel_e                    relation;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;
  } sic_out_t;

endpackage

FILE: rtl/sic_front.sv
// front pipeline: differences, cross products, sign normalization, classification, numerator products
module sic_front import sic_pkg::*; #(
  parameter int CW = 16,
  parameter int DW = CW + 1,
  parameter int PW = 2 * DW,
  parameter int SW = PW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  sic_in_t              data_i,
  output logic                 valid_o,
  output logic [SW+DW-1:0]     prod_x_o,
  output logic [SW+DW-1:0]     prod_y_o,
  output logic [SW-1:0]        den_o,
  output rel_e                 rel_o,
  output logic                 neg_x_o,
  output logic                 neg_y_o,
  output logic signed [CW-1:0] ax_o,
  output logic signed [CW-1:0] ay_o
);

  logic [4:0] vld_q;

  logic signed [CW-1:0] ax, ay, aex, aey, bx, by, bex, bey;
  assign ax  = $signed(data_i.a_start_x[CW-1:0]);
  assign ay  = $signed(data_i.a_start_y[CW-1:0]);
  assign aex = $signed(data_i.a_end_x[CW-1:0]);
  assign aey = $signed(data_i.a_end_y[CW-1:0]);
  assign bx  = $signed(data_i.b_start_x[CW-1:0]);
  assign by  = $signed(data_i.b_start_y[CW-1:0]);
  assign bex = $signed(data_i.b_end_x[CW-1:0]);
  assign bey = $signed(data_i.b_end_y[CW-1:0]);

  // stage 1
  logic signed [DW-1:0] dax1_q, day1_q, dbx1_q, dby1_q, ex1_q, ey1_q;
  logic signed [CW-1:0] ax1_q, ay1_q;
  logic                 same1_q;
  // stage 2
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [DW-1:0] dax2_q, day2_q;
  logic signed [CW-1:0] ax2_q, ay2_q;
  logic                 same2_q;
  // stage 3
  logic signed [SW-1:0] den3_q, na3_q, nb3_q;
  logic signed [DW-1:0] dax3_q, day3_q;
  logic signed [CW-1:0] ax3_q, ay3_q;
  logic                 same3_q;
  // stage 4
  logic [SW-1:0]        den4_q, na4_q;
  logic [DW-1:0]        adx4_q, ady4_q;
  logic                 negx4_q, negy4_q;
  rel_e                 rel4_q;
  logic signed [CW-1:0] ax4_q, ay4_q;
  // stage 5
  logic [SW+DW-1:0]     px5_q, py5_q;
  logic [SW-1:0]        den5_q;
  logic                 negx5_q, negy5_q;
  rel_e                 rel5_q;
  logic signed [CW-1:0] ax5_q, ay5_q;

  logic                 same_d;
  logic                 flip;
  logic signed [SW-1:0] den_n, na_n, nb_n;
  rel_e                 rel_d;

  assign same_d = (ax == bx && ay == by && aex == bex && aey == bey) ||
                  (ax == bex && ay == bey && aex == bx && aey == by);

  assign flip = den3_q < 0;
  assign den_n = flip ? -den3_q : den3_q;
  assign na_n  = flip ? -na3_q : na3_q;
  assign nb_n  = flip ? -nb3_q : nb3_q;

  always_comb begin
    if (same3_q) begin
      rel_d = REL_OVERLAP;
    end else if (den3_q == '0) begin
      rel_d = (na3_q == '0 && nb3_q == '0) ? REL_OVERLAP : REL_PARALLEL;
    end else if (na_n >= 0 && na_n <= den_n && nb_n >= 0 && nb_n <= den_n) begin
      rel_d = REL_HIT;
    end else begin
      rel_d = REL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dax1_q  <= DW'(aex) - DW'(ax);
      day1_q  <= DW'(aey) - DW'(ay);
      dbx1_q  <= DW'(bex) - DW'(bx);
      dby1_q  <= DW'(bey) - DW'(by);
      ex1_q   <= DW'(ax) - DW'(bx);
      ey1_q   <= DW'(ay) - DW'(by);
      ax1_q   <= ax;
      ay1_q   <= ay;
      same1_q <= same_d;

      p1_q    <= PW'(dby1_q) * PW'(dax1_q);
      p2_q    <= PW'(dbx1_q) * PW'(day1_q);
      p3_q    <= PW'(dbx1_q) * PW'(ey1_q);
      p4_q    <= PW'(dby1_q) * PW'(ex1_q);
      p5_q    <= PW'(dax1_q) * PW'(ey1_q);
      p6_q    <= PW'(day1_q) * PW'(ex1_q);
      dax2_q  <= dax1_q;
      day2_q  <= day1_q;
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      same2_q <= same1_q;

      den3_q  <= SW'(p1_q) - SW'(p2_q);
      na3_q   <= SW'(p3_q) - SW'(p4_q);
      nb3_q   <= SW'(p5_q) - SW'(p6_q);
      dax3_q  <= dax2_q;
      day3_q  <= day2_q;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      same3_q <= same2_q;

      den4_q  <= den_n;
      na4_q   <= na_n;
      adx4_q  <= (dax3_q < 0) ? -dax3_q : dax3_q;
      ady4_q  <= (day3_q < 0) ? -day3_q : day3_q;
      negx4_q <= dax3_q < 0;
      negy4_q <= day3_q < 0;
      rel4_q  <= rel_d;
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;

      px5_q   <= (SW+DW)'(na4_q) * (SW+DW)'(adx4_q);
      py5_q   <= (SW+DW)'(na4_q) * (SW+DW)'(ady4_q);
      den5_q  <= den4_q;
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
      rel5_q  <= rel4_q;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;
    end
  end

  assign valid_o  = vld_q[4];
  assign prod_x_o = px5_q;
  assign prod_y_o = py5_q;
  assign den_o    = den5_q;
  assign rel_o    = rel5_q;
  assign neg_x_o  = negx5_q;
  assign neg_y_o  = negy5_q;
  assign ax_o     = ax5_q;
  assign ay_o     = ay5_q;

endmodule

FILE: rtl/sic_div.sv
// pipelined restoring divider, one quotient bit per stage
module sic_div #(
  parameter int SW  = 35,
  parameter int QB  = 25,
  parameter int SBW = 8,
  parameter int NW  = SW + QB
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [NW-1:0]  num_i,
  input  logic [SW-1:0]  den_i,
  input  logic [SBW-1:0] side_i,
  output logic [QB-1:0]  quo_o,
  output logic           rem_nz_o,
  output logic [SBW-1:0] side_o
);

  logic [SW-1:0]  r_q   [QB];
  logic [QB-1:0]  lo_q  [QB];
  logic [QB-1:0]  qu_q  [QB];
  logic [SW-1:0]  dn_q  [QB];
  logic [SBW-1:0] sb_q  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [SW-1:0]  r_p, dn_p;
    logic [QB-1:0]  lo_p, qu_p;
    logic [SBW-1:0] sb_p;
    logic [SW:0]    t, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign r_p  = num_i[NW-1:QB];
      assign lo_p = num_i[QB-1:0];
      assign qu_p = '0;
      assign dn_p = den_i;
      assign sb_p = side_i;
    end else begin : g_next
      assign r_p  = r_q[k-1];
      assign lo_p = lo_q[k-1];
      assign qu_p = qu_q[k-1];
      assign dn_p = dn_q[k-1];
      assign sb_p = sb_q[k-1];
    end

    assign t    = {r_p, lo_p[QB-1]};
    assign diff = t - {1'b0, dn_p};
    assign ge   = t >= {1'b0, dn_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= ge ? diff[SW-1:0] : t[SW-1:0];
        lo_q[k] <= lo_p << 1;
        qu_q[k] <= (qu_p << 1) | QB'(ge);
        dn_q[k] <= dn_p;
        sb_q[k] <= sb_p;
      end
    end
  end

  assign quo_o    = qu_q[QB-1];
  assign rem_nz_o = |r_q[QB-1];
  assign side_o   = sb_q[QB-1];

endmodule

FILE: rtl/segment_intersection_classify_top.sv
// top level of the segment intersection classifier
//
// input channel in_valid_i/in_ready_o carries one word with both segments'
// endpoints; output channel out_valid_o/out_ready_i returns one word per
// input word, in order, with the relation code and the fixed-point point.
// a word passes from acceptance to a valid output through five front
// stages, one divider stage per quotient bit and the output register.
// one word is accepted every cycle while the output is taken. the whole
// pipeline advances on a single enable: when the output holds a word
// that is not taken, every stage holds and in_ready_o drops, so nothing
// is lost or repeated. reset clears all valid bits; no word is in flight
// after reset.
module segment_intersection_classify_top import sic_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sic_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sic_out_t out_data_o
);

  localparam int CW  = (COORD_BITS > FIELD_W) ? FIELD_W : COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int QB  = DW + FRAC_BITS;
  localparam int NW  = SW + QB;
  localparam int VW  = QB + 2;
  localparam int EW  = (VW > OUT_W) ? VW : OUT_W;
  localparam int SXW = 2 + 1 + CW;
  localparam int SYW = 1 + CW;

  logic en;

  logic                 f_valid;
  logic [SW+DW-1:0]     f_px, f_py;
  logic [SW-1:0]        f_den;
  rel_e                 f_rel;
  logic                 f_negx, f_negy;
  logic signed [CW-1:0] f_ax, f_ay;

  logic [QB-1:0]        vld_q;
  logic [QB-1:0]        qx, qy;
  logic                 rzx, rzy;
  logic [SXW-1:0]       sx;
  logic [SYW-1:0]       sy;

  rel_e                 d_rel;
  logic                 d_negx, d_negy;
  logic signed [CW-1:0] d_ax, d_ay;
  logic signed [VW-1:0] cx, cy, vx, vy;
  logic signed [EW-1:0] wx, wy;
  logic signed [OUT_W-1:0] ox, oy;

  logic     out_valid_q;
  sic_out_t out_q;
  sic_out_t out_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  sic_front #(.CW(CW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .data_i   (in_data_i),
    .valid_o  (f_valid),
    .prod_x_o (f_px),
    .prod_y_o (f_py),
    .den_o    (f_den),
    .rel_o    (f_rel),
    .neg_x_o  (f_negx),
    .neg_y_o  (f_negy),
    .ax_o     (f_ax),
    .ay_o     (f_ay)
  );

  sic_div #(.SW(SW), .QB(QB), .SBW(SXW)) u_div_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (NW'(f_px) << FRAC_BITS),
    .den_i    (f_den),
    .side_i   ({f_rel, f_negx, f_ax}),
    .quo_o    (qx),
    .rem_nz_o (rzx),
    .side_o   (sx)
  );

  sic_div #(.SW(SW), .QB(QB), .SBW(SYW)) u_div_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (NW'(f_py) << FRAC_BITS),
    .den_i    (f_den),
    .side_i   ({f_negy, f_ay}),
    .quo_o    (qy),
    .rem_nz_o (rzy),
    .side_o   (sy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= (vld_q << 1) | QB'(f_valid);
    end
  end

  assign d_rel  = rel_e'(sx[SXW-1 -: 2]);
  assign d_negx = sx[CW];
  assign d_ax   = $signed(sx[CW-1:0]);
  assign d_negy = sy[CW];
  assign d_ay   = $signed(sy[CW-1:0]);

  // floor toward minus infinity for a negative slope
  assign cx = d_negx ? -($signed({2'b00, qx}) + VW'(rzx)) : $signed({2'b00, qx});
  assign cy = d_negy ? -($signed({2'b00, qy}) + VW'(rzy)) : $signed({2'b00, qy});
  assign vx = (VW'(d_ax) <<< FRAC_BITS) + cx;
  assign vy = (VW'(d_ay) <<< FRAC_BITS) + cy;
  assign wx = EW'(vx);
  assign wy = EW'(vy);

  always_comb begin
    if (wx > EW'(OUT_MAX)) begin
      ox = OUT_MAX;
    end else if (wx < EW'(OUT_MIN)) begin
      ox = OUT_MIN;
    end else begin
      ox = OUT_W'(wx);
    end
    if (wy > EW'(OUT_MAX)) begin
      oy = OUT_MAX;
    end else if (wy < EW'(OUT_MIN)) begin
      oy = OUT_MIN;
    end else begin
      oy = OUT_W'(wy);
    end
  end

  always_comb begin
    out_d.relation = d_rel;
    out_d.cross_x  = (d_rel == REL_HIT) ? ox : '0;
    out_d.cross_y  = (d_rel == REL_HIT) ? oy : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_zero_unless_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.relation != REL_HIT |->
      out_data_o.cross_x == '0 && out_data_o.cross_y == '0)
    else $error("point not zero for a non-hit word");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not track output stage");

endmodule
